>>> rtl/core/wfdc_pkg.sv
// ---------------------------------------------------------------------------
// wfdc_pkg
// Shared types, constants and codes for the wall-following drive controller
// ---------------------------------------------------------------------------
package wfdc_pkg;

    localparam int SIDE_SENSOR_COUNT_DEF = 4;

    localparam logic [7:0] NO_WALL        = 8'd245;
    localparam logic [7:0] NEAR_LIMIT     = 8'd25;
    localparam logic [6:0] OBST_TURN_SPD  = 7'd70;
    localparam logic [7:0] GYRO_ZERO      = 8'd124;
    localparam logic [7:0] MANUAL_FWD_SPD = 8'd50;

    // divide by 1000 as multiply by ceil(2^35/1000) then shift
    localparam logic signed [26:0] RECIP_1000  = 27'sd34359739;
    localparam int                 RECIP_SHIFT = 35;

    // result actions
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_OPEN  = 2'd2;
    localparam logic [1:0] ACT_CLOSE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_AUTO   = 3'd0;
    localparam logic [2:0] CFG_PGAIN  = 3'd1;
    localparam logic [2:0] CFG_DGAIN  = 3'd2;
    localparam logic [2:0] CFG_KGAIN  = 3'd3;
    localparam logic [2:0] CFG_CRUISE = 3'd4;

    // sensor numbers
    localparam logic [7:0] SNS_FWD_HI = 8'd5;
    localparam logic [7:0] SNS_FWD_LO = 8'd6;
    localparam logic [7:0] SNS_GYRO   = 8'd7;

    // direction codes
    localparam logic [7:0] DIR_FWD    = 8'd1;
    localparam logic [7:0] DIR_BACK   = 8'd2;
    localparam logic [7:0] DIR_LEFT   = 8'd3;
    localparam logic [7:0] DIR_RIGHT  = 8'd4;
    localparam logic [7:0] DIR_FL     = 8'd5;
    localparam logic [7:0] DIR_FR     = 8'd6;
    localparam logic [7:0] DIR_BL     = 8'd7;
    localparam logic [7:0] DIR_BR     = 8'd8;
    localparam logic [7:0] DIR_PICKER = 8'd9;
    localparam logic [7:0] DIR_ROT2   = 8'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_D,
        ST_SUM,
        ST_MUL_K,
        ST_DIV,
        ST_FINISH,
        ST_MIX,
        ST_OUT
    } state_t;

    // command from sequencer to shared multiplier
    typedef struct packed {
        logic               start;
        logic signed [26:0] a;
        logic signed [26:0] b;
    } mul_cmd_t;

endpackage

>>> rtl/core/wfdc_mul.sv
// ---------------------------------------------------------------------------
// wfdc_mul
// Shared signed multiplier with registered product
// ---------------------------------------------------------------------------
module wfdc_mul
    import wfdc_pkg::*;
(
    input  logic               clk,
    input  mul_cmd_t           cmd,
    output logic signed [53:0] product
);

    logic signed [53:0] product_reg;

    // one product per issued command
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            product_reg <= cmd.a * cmd.b;
        end
    end

    assign product = product_reg;

endmodule

>>> rtl/core/wall_following_drive_controller_unit.sv
// ---------------------------------------------------------------------------
// wall_following_drive_controller_unit
// Sensor and command driven wheel controller with a PD wall follower
// ---------------------------------------------------------------------------
// channel  | dir | tdata (low bit first)                | other
// s_axis   | in  | index[7:0], value[15:8]              | tuser = mode
// m_axis   | out | l_speed[7:0], l_fwd[8], r_speed[16:9],| tuser = action
//          |     | r_fwd[17], zero pad [23:18]          |
// cfg      | in  | cfg_index (3b), cfg_data (8b)        | cfg_valid/ready
// An item with an immediate result is taken, then its result beat is offered;
// an item with no result is only taken. The autonomous forward drive with a
// wall runs p, d, sum, k, reciprocal divide, finish and mix steps around the
// one multiplier, then the result beat. Reset clears the sequencer and the
// persistent state and loads the configuration defaults; the pd datapath and
// result registers are not reset. A result waits in the output register; no new item is taken until it goes.
// ---------------------------------------------------------------------------
module wall_following_drive_controller_unit
    import wfdc_pkg::*;
#(
    parameter int SIDE_SENSOR_COUNT = SIDE_SENSOR_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // index, value
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // left_speed, left_forward, right_speed, right_forward
    output logic [1:0]  m_axis_tuser,   // action
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int SW = $clog2(SIDE_SENSOR_COUNT);

    state_t state_reg, state_next;

    logic       auto_reg;
    logic [7:0] pg_reg, dg_reg, kg_reg, cruise_reg;
    logic [7:0] side_reg [SIDE_SENSOR_COUNT];
    logic [7:0] fwd_hi_reg;
    logic       turn_reg;
    logic [15:0] acc_reg;
    logic [6:0] tspd_reg;

    logic        flip_reg;
    logic        neg_reg;
    logic signed [18:0] err_reg, dterm_reg;
    logic signed [15:0] y_reg;

    logic [1:0] o_act_reg;
    logic [7:0] o_ls_reg, o_rs_reg;
    logic       o_lf_reg, o_rf_reg;

    mul_cmd_t mcmd;
    logic signed [53:0] prod;

    wfdc_mul u_mul (.clk(clk), .cmd(mcmd), .product(prod));

    logic       in_acc;
    logic       mode;
    logic [7:0] idx, val;
    assign mode = s_axis_tuser;
    assign idx  = s_axis_tdata[7:0];
    assign val  = s_axis_tdata[15:8];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tuser  = o_act_reg;
    assign m_axis_tdata  = {6'd0, o_rf_reg, o_rs_reg, o_lf_reg, o_ls_reg};

    function automatic logic [7:0] sat8(input logic signed [16:0] v);
        logic [7:0] r;
        if (v < 0)
            r = 8'd0;
        else if (v > 17'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

    // decode of the accepted beat: immediate result, start of pd chain or turn state update
    logic       imm_res, imm_go_pd, imm_start_turn, imm_stop_turn, imm_add;
    logic [1:0] imm_act;
    logic [7:0] imm_ls, imm_rs;
    logic       imm_lf, imm_rf, imm_clr_acc, imm_set_tspd;
    logic       fwd_req;
    logic [17:0] r6_prod;
    logic [7:0] r6;
    logic [15:0] fwd_dist;
    logic signed [8:0]  g;
    logic signed [19:0] thr_lhs, thr_rhs;
    logic [7:0] sf, sb;
    logic       lw, rw;
    logic [8:0] ssum;

    // floor of 0.6 v as v * 615 / 1024, exact over the byte range
    assign r6_prod = 18'(val) * 18'd615;
    assign r6 = r6_prod[17:10];
    assign fwd_dist = {fwd_hi_reg, val};
    assign g = $signed({1'b0, val}) - $signed({1'b0, GYRO_ZERO});
    assign thr_lhs = 20'(signed'(acc_reg)) * 20'sd10;
    assign thr_rhs = 20'sd8410 - 20'sd34 * $signed({13'd0, tspd_reg});
    assign lw = side_reg[1] != NO_WALL;
    assign rw = side_reg[2] != NO_WALL;
    assign sf = lw ? side_reg[1] : side_reg[0];
    assign sb = lw ? side_reg[3] : side_reg[2];
    assign ssum = {1'b0, sf} + {1'b0, sb};

    always_comb
    begin
        imm_res = 1'b0; imm_go_pd = 1'b0; imm_start_turn = 1'b0;
        imm_stop_turn = 1'b0; imm_add = 1'b0; imm_clr_acc = 1'b0;
        imm_set_tspd = 1'b0; fwd_req = 1'b0;
        imm_act = ACT_SET; imm_ls = 8'd0; imm_rs = 8'd0; imm_lf = 1'b0; imm_rf = 1'b0;
        if (mode)
        begin
            if (!auto_reg)
            begin
                imm_res = 1'b1; imm_ls = val; imm_rs = val;
                case (idx)
                    DIR_FWD:   begin imm_lf = 1'b1; imm_rf = 1'b1; end
                    DIR_BACK:  ;
                    DIR_LEFT:  imm_rf = 1'b1;
                    DIR_RIGHT: imm_lf = 1'b1;
                    DIR_FL:    begin imm_lf = 1'b1; imm_rf = 1'b1; imm_rs = r6; end
                    DIR_FR:    begin imm_lf = 1'b1; imm_rf = 1'b1; imm_ls = r6; end
                    DIR_BL:    imm_rs = r6;
                    DIR_BR:    imm_ls = r6;
                    DIR_PICKER:
                    begin
                        imm_act = (val == 8'd1) ? ACT_OPEN : ACT_CLOSE;
                        imm_ls = 8'd0; imm_rs = 8'd0;
                    end
                    default:   imm_res = 1'b0;
                endcase
            end
            else
            begin
                case (idx)
                    DIR_FWD:   fwd_req = 1'b1;
                    DIR_LEFT:  begin imm_clr_acc = 1'b1; imm_ls = 8'd1; end
                    DIR_RIGHT: begin imm_clr_acc = 1'b1; imm_ls = 8'd0; end
                    DIR_ROT2:  begin imm_clr_acc = 1'b1; imm_ls = 8'd2; end
                    default:   ;
                endcase
            end
        end
        else if (idx == SNS_FWD_LO && !turn_reg)
        begin
            if (fwd_dist < {8'd0, NEAR_LIMIT})
            begin
                imm_set_tspd = 1'b1; imm_clr_acc = 1'b1; imm_ls = {1'b0, OBST_TURN_SPD};
            end
            else if (!auto_reg)
            begin
                imm_res = 1'b1; imm_ls = MANUAL_FWD_SPD; imm_rs = MANUAL_FWD_SPD;
                imm_lf = 1'b1; imm_rf = 1'b1;
            end
            else
                fwd_req = 1'b1;
        end
        else if (idx == SNS_GYRO)
        begin
            if (turn_reg && thr_lhs > thr_rhs)
            begin
                imm_res = 1'b1; imm_stop_turn = 1'b1; imm_act = ACT_STOP;
            end
            else if (turn_reg && (g > 9'sd3 || g < -9'sd3))
                imm_add = 1'b1;
        end
        // rotate: result only when no turn is running
        if (imm_clr_acc && !turn_reg)
        begin
            imm_res = 1'b1; imm_start_turn = 1'b1; imm_rs = imm_ls;
            imm_lf = 1'b0; imm_rf = 1'b1;
        end
        // autonomous forward drive
        if (fwd_req)
        begin
            if (!lw && !rw)
            begin
                imm_res = 1'b1; imm_ls = cruise_reg; imm_rs = cruise_reg;
                imm_lf = 1'b1; imm_rf = 1'b1;
            end
            else
                imm_go_pd = 1'b1;
        end
    end

    // sequencer: shared multiplier issue
    always_comb
    begin
        state_next = state_reg;
        mcmd.start = 1'b0;
        mcmd.a = '0;
        mcmd.b = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && imm_go_pd)
                    state_next = ST_MUL_P;
                else if (in_acc && imm_res)
                    state_next = ST_OUT;
            end
            ST_MUL_P:
            begin
                mcmd.start = 1'b1; mcmd.a = 27'(err_reg);
                mcmd.b = 27'($signed({1'b0, pg_reg}));
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                mcmd.start = 1'b1; mcmd.a = 27'(dterm_reg);
                mcmd.b = 27'($signed({1'b0, dg_reg}));
                state_next = ST_SUM;
            end
            ST_SUM:    state_next = ST_MUL_K;
            ST_MUL_K:
            begin
                mcmd.start = 1'b1; mcmd.a = 27'(err_reg);
                mcmd.b = 27'($signed({1'b0, kg_reg}));
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // magnitude times ceil(2^35/1000)
                mcmd.start = 1'b1;
                mcmd.a = 27'(prod);
                mcmd.b = RECIP_1000;
                state_next = ST_FINISH;
            end
            ST_FINISH: state_next = ST_MIX;
            ST_MIX:    state_next = ST_OUT;
            ST_OUT:    if (m_axis_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg <= 1'b0; pg_reg <= 8'd45; dg_reg <= 8'd120;
            kg_reg <= 8'd7; cruise_reg <= 8'd30;
            for (int i = 0; i < SIDE_SENSOR_COUNT; i++) side_reg[i] <= 8'd0;
            fwd_hi_reg <= 8'd0; turn_reg <= 1'b0; acc_reg <= 16'd0; tspd_reg <= 7'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_AUTO:   auto_reg <= cfg_data[0];
                    CFG_PGAIN:  pg_reg <= cfg_data;
                    CFG_DGAIN:  dg_reg <= cfg_data;
                    CFG_KGAIN:  kg_reg <= cfg_data;
                    CFG_CRUISE: cruise_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (in_acc)
            begin
                if (!mode && idx >= 8'd1 && idx <= 8'(SIDE_SENSOR_COUNT))
                    side_reg[SW'(idx - 8'd1)] <= val;
                if (!mode && idx == SNS_FWD_HI)
                    fwd_hi_reg <= val;
                if (imm_set_tspd)
                    tspd_reg <= OBST_TURN_SPD;
                if (imm_clr_acc)
                    acc_reg <= 16'd0;
                if (imm_start_turn)
                    turn_reg <= 1'b1;
                if (imm_stop_turn)
                    turn_reg <= 1'b0;
                if (imm_add)
                    acc_reg <= acc_reg + 16'(signed'(g));
            end
        end
    end

    // pd sum magnitude, quotient and signed y
    logic signed [18:0] sum_v, abs_v;
    logic signed [15:0] q_mag, y_next;
    assign sum_v  = err_reg + 19'(prod);
    assign abs_v  = sum_v[18] ? -sum_v : sum_v;
    assign q_mag  = 16'(prod >>> RECIP_SHIFT);
    assign y_next = (neg_reg ^ flip_reg) ? -q_mag : q_mag;

    // wheel mix from the registered y
    logic signed [16:0] yx, cr, hx;
    logic signed [15:0] hy;
    logic [7:0] mix_ls, mix_rs;
    assign yx = 17'(y_reg);
    assign cr = $signed({9'd0, cruise_reg});
    assign hy = y_reg / 16'sd2;
    assign hx = 17'(hy);

    always_comb
    begin
        if (y_reg < 0 && cr - yx > 17'sd100)
        begin
            mix_ls = 8'd100; mix_rs = sat8(17'sd100 + yx);
        end
        else if (y_reg >= 0 && cr + yx > 17'sd100)
        begin
            mix_ls = sat8(17'sd100 - yx); mix_rs = 8'd100;
        end
        else
        begin
            mix_ls = sat8(cr - hx); mix_rs = sat8(cr + hx);
        end
    end

    // pd datapath and result register
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            flip_reg  <= !lw;
            err_reg   <= 19'($signed({1'b0, ssum[8:1]})) - 19'sd100;
            dterm_reg <= 19'($signed({1'b0, sf})) - 19'($signed({1'b0, sb}));
            o_act_reg <= imm_act; o_ls_reg <= imm_ls; o_rs_reg <= imm_rs;
            o_lf_reg <= imm_lf; o_rf_reg <= imm_rf;
        end
        case (state_reg)
            ST_MUL_D:  err_reg <= 19'(prod);
            ST_SUM:
            begin
                neg_reg <= sum_v[18];
                err_reg <= abs_v;
            end
            ST_FINISH: y_reg <= y_next;
            ST_MIX:
            begin
                o_act_reg <= ACT_SET; o_lf_reg <= 1'b1; o_rf_reg <= 1'b1;
                o_ls_reg <= mix_ls; o_rs_reg <= mix_rs;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/core/wfdc_checker.sv
// ---------------------------------------------------------------------------
// wfdc_checker
// Port-level checks for the wall-following drive controller
// ---------------------------------------------------------------------------
module wfdc_checker
    import wfdc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // no input taken while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // non-wheel actions carry no speeds
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ACT_SET |-> m_axis_tdata == 24'd0)
        else $error("speed on non-wheel action");

    // pad bits stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0) else $error("pad bits set");

endmodule

bind wall_following_drive_controller_unit wfdc_checker u_wfdc_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
